FILE: sv/sbst_pkg.sv
// Package for the segment versus box slab test.
// Holds register indexes, fixed widths, the lane sideband type and the face code helper.
// Used by the interfaces and by every module of the block.
`default_nettype none
package sbst_pkg;

  localparam int NUM_AXES = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;
  localparam int COORD_W = 32;
  localparam int SPAN_W = COORD_W + 1;
  localparam int REM_W = SPAN_W + 1;
  localparam int CODE_W = 3;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_BOX_MIN_X = 3'd0,
    REG_BOX_MIN_Y = 3'd1,
    REG_BOX_MIN_Z = 3'd2,
    REG_BOX_MAX_X = 3'd3,
    REG_BOX_MAX_Y = 3'd4,
    REG_BOX_MAX_Z = 3'd5
  } cfg_reg_t;

  localparam logic [CODE_W-1:0] FACE_NONE = 3'd0;

  typedef struct packed {
    logic [NUM_AXES-1:0] miss;
    logic [NUM_AXES-1:0] st_use;
    logic [NUM_AXES-1:0] et_use;
    logic [NUM_AXES-1:0] fwd;
  } side_t;

  function automatic logic [CODE_W-1:0] face_code(input logic [1:0] axis, input logic fwd);
    logic [CODE_W-1:0] base;
    base = {axis, 1'b0};
    return fwd ? base + 3'd1 : base + 3'd2;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sbst_ifs.sv
// Channel interfaces for the segment versus box slab test: segments in, results out, config.
// Depends on sbst_pkg for field widths.
`default_nettype none
interface sbst_seg_if;
  logic valid;
  logic ready;
  logic signed [sbst_pkg::COORD_W-1:0] start_x;
  logic signed [sbst_pkg::COORD_W-1:0] start_y;
  logic signed [sbst_pkg::COORD_W-1:0] start_z;
  logic signed [sbst_pkg::COORD_W-1:0] end_x;
  logic signed [sbst_pkg::COORD_W-1:0] end_y;
  logic signed [sbst_pkg::COORD_W-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

interface sbst_res_if #(parameter int TIME_W = 17);
  logic valid;
  logic ready;
  logic hit;
  logic [TIME_W-1:0] hit_time;
  logic [sbst_pkg::CODE_W-1:0] normal_code;
  modport source (output valid, hit, hit_time, normal_code, input ready);
  modport sink (input valid, hit, hit_time, normal_code, output ready);
endinterface

interface sbst_cfg_if;
  logic valid;
  logic ready;
  logic [sbst_pkg::IDX_W-1:0] index;
  logic [sbst_pkg::COORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/segment_box_slab_test_top.sv
// Top level of the segment versus axis-aligned box slab test.
// Depends on sbst_pkg, the channel interfaces, sbst_front, sbst_div_cell and sbst_resolve.
//
// Takes one segment per cycle while the output is not stalled and returns one result per
// segment, in order, through one front stage, a chain of FRACTION_BITS+1 division cells
// producing one quotient bit each for all six entry and exit times, and the output register.
// The whole chain stalls only while a result waits at the output. Box bounds are written
// through the config channel, which is always ready; writes to indexes above five are ignored.
`default_nettype none
module segment_box_slab_test_top #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sbst_seg_if.sink in_ch,
  sbst_res_if.source out_ch,
  sbst_cfg_if.sink cfg_ch
);

  localparam int QW = FRACTION_BITS + 1;

  logic [sbst_pkg::NUM_AXES-1:0][sbst_pkg::COORD_W-1:0] box_lo_r, box_hi_r;
  logic [sbst_pkg::NUM_AXES-1:0][sbst_pkg::COORD_W-1:0] seg_s, seg_e;
  logic advance;

  logic [QW:0] vld;
  logic [QW:0][sbst_pkg::NUM_LANES-1:0][sbst_pkg::REM_W-1:0] rem;
  logic [QW:0][sbst_pkg::NUM_LANES-1:0][sbst_pkg::SPAN_W-1:0] den;
  logic [QW:0][sbst_pkg::NUM_LANES-1:0][QW-1:0] quo;
  sbst_pkg::side_t side [QW+1];

  logic res_hit;
  logic [QW-1:0] res_time;
  logic [sbst_pkg::CODE_W-1:0] res_code;

  logic out_valid_r, hit_r;
  logic [QW-1:0] time_r;
  logic [sbst_pkg::CODE_W-1:0] code_r;

  assign advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign cfg_ch.ready = 1'b1;

  assign seg_s = {in_ch.start_z, in_ch.start_y, in_ch.start_x};
  assign seg_e = {in_ch.end_z, in_ch.end_y, in_ch.end_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_lo_r <= '0;
      box_hi_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        sbst_pkg::REG_BOX_MIN_X: box_lo_r[0] <= cfg_ch.data;
        sbst_pkg::REG_BOX_MIN_Y: box_lo_r[1] <= cfg_ch.data;
        sbst_pkg::REG_BOX_MIN_Z: box_lo_r[2] <= cfg_ch.data;
        sbst_pkg::REG_BOX_MAX_X: box_hi_r[0] <= cfg_ch.data;
        sbst_pkg::REG_BOX_MAX_Y: box_hi_r[1] <= cfg_ch.data;
        sbst_pkg::REG_BOX_MAX_Z: box_hi_r[2] <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  sbst_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .en(advance),
    .in_valid(in_ch.valid),
    .seg_s(seg_s),
    .seg_e(seg_e),
    .box_lo(box_lo_r),
    .box_hi(box_hi_r),
    .valid_r(vld[0]),
    .rem_r(rem[0]),
    .den_r(den[0]),
    .side_r(side[0])
  );

  assign quo[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    sbst_div_cell #(
      .QW(QW),
      .FIRST(k == 0)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .en(advance),
      .valid_in(vld[k]),
      .rem_in(rem[k]),
      .den_in(den[k]),
      .quo_in(quo[k]),
      .side_in(side[k]),
      .valid_r(vld[k+1]),
      .rem_r(rem[k+1]),
      .den_r(den[k+1]),
      .quo_r(quo[k+1]),
      .side_r(side[k+1])
    );
  end

  sbst_resolve #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_resolve (
    .quo(quo[QW]),
    .side(side[QW]),
    .hit(res_hit),
    .hit_time(res_time),
    .normal_code(res_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hit_r <= res_hit;
      time_r <= res_time;
      code_r <= res_code;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit = hit_r;
  assign out_ch.hit_time = time_r;
  assign out_ch.normal_code = code_r;

endmodule
`default_nettype wire

FILE: sv/sbst_front.sv
// Front stage: per-axis slab classification, numerators and spans for the divider chain.
// Depends on sbst_pkg.
`default_nettype none
module sbst_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic [sbst_pkg::NUM_AXES-1:0][sbst_pkg::COORD_W-1:0] seg_s,
  input  wire logic [sbst_pkg::NUM_AXES-1:0][sbst_pkg::COORD_W-1:0] seg_e,
  input  wire logic [sbst_pkg::NUM_AXES-1:0][sbst_pkg::COORD_W-1:0] box_lo,
  input  wire logic [sbst_pkg::NUM_AXES-1:0][sbst_pkg::COORD_W-1:0] box_hi,
  output logic valid_r,
  output logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::REM_W-1:0] rem_r,
  output logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::SPAN_W-1:0] den_r,
  output sbst_pkg::side_t side_r
);

  logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::REM_W-1:0] rem_nxt;
  logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::SPAN_W-1:0] den_nxt;
  sbst_pkg::side_t side_nxt;

  always_comb begin
    logic signed [sbst_pkg::SPAN_W-1:0] s, e, lo, hi;
    logic signed [sbst_pkg::SPAN_W-1:0] nst, net, dd;
    logic fwd;
    side_nxt = '0;
    rem_nxt = '0;
    den_nxt = '0;
    for (int a = 0; a < sbst_pkg::NUM_AXES; a++) begin
      s = $signed({seg_s[a][sbst_pkg::COORD_W-1], seg_s[a]});
      e = $signed({seg_e[a][sbst_pkg::COORD_W-1], seg_e[a]});
      lo = $signed({box_lo[a][sbst_pkg::COORD_W-1], box_lo[a]});
      hi = $signed({box_hi[a][sbst_pkg::COORD_W-1], box_hi[a]});
      fwd = s < e;
      side_nxt.fwd[a] = fwd;
      side_nxt.miss[a] = fwd ? (s > hi || e < lo) : (e > hi || s < lo);
      side_nxt.st_use[a] = fwd ? (s < lo) : (s > hi);
      side_nxt.et_use[a] = fwd ? (e > hi) : (e < lo);
      nst = fwd ? lo - s : s - hi;
      net = fwd ? hi - s : s - lo;
      dd = fwd ? e - s : s - e;
      rem_nxt[2*a] = {1'b0, nst};
      rem_nxt[2*a+1] = {1'b0, net};
      den_nxt[2*a] = dd;
      den_nxt[2*a+1] = dd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_nxt;
      side_r <= side_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sbst_div_cell.sv
// One restoring division step for all six lanes; cells chain to form the divider pipeline.
// Depends on sbst_pkg.
`default_nettype none
module sbst_div_cell #(
  parameter int QW = 17,
  parameter bit FIRST = 1'b0
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic valid_in,
  input  wire logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::REM_W-1:0] rem_in,
  input  wire logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::SPAN_W-1:0] den_in,
  input  wire logic [sbst_pkg::NUM_LANES-1:0][QW-1:0] quo_in,
  input  wire sbst_pkg::side_t side_in,
  output logic valid_r,
  output logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::REM_W-1:0] rem_r,
  output logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::SPAN_W-1:0] den_r,
  output logic [sbst_pkg::NUM_LANES-1:0][QW-1:0] quo_r,
  output sbst_pkg::side_t side_r
);

  logic [sbst_pkg::NUM_LANES-1:0][sbst_pkg::REM_W-1:0] rem_nxt;
  logic [sbst_pkg::NUM_LANES-1:0][QW-1:0] quo_nxt;

  always_comb begin
    logic [sbst_pkg::REM_W-1:0] t;
    logic ge;
    for (int l = 0; l < sbst_pkg::NUM_LANES; l++) begin
      t = FIRST ? rem_in[l] : {rem_in[l][sbst_pkg::REM_W-2:0], 1'b0};
      ge = t >= {1'b0, den_in[l]};
      rem_nxt[l] = ge ? t - {1'b0, den_in[l]} : t;
      quo_nxt[l] = {quo_in[l][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      den_r <= den_in;
      quo_r <= quo_nxt;
      side_r <= side_in;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sbst_resolve.sv
// Merges the per-axis entry and exit times into hit, entry time and entered face.
// Depends on sbst_pkg.
`default_nettype none
module sbst_resolve #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic [sbst_pkg::NUM_LANES-1:0][FRACTION_BITS:0] quo,
  input  wire sbst_pkg::side_t side,
  output logic hit,
  output logic [FRACTION_BITS:0] hit_time,
  output logic [sbst_pkg::CODE_W-1:0] normal_code
);

  localparam logic [FRACTION_BITS:0] ONE_T = {1'b1, {FRACTION_BITS{1'b0}}};

  always_comb begin
    logic [FRACTION_BITS:0] fst, fet, st, et;
    logic [sbst_pkg::CODE_W-1:0] code;
    logic alive;
    fst = '0;
    fet = ONE_T;
    code = sbst_pkg::FACE_NONE;
    alive = 1'b1;
    for (int a = 0; a < sbst_pkg::NUM_AXES; a++) begin
      st = side.st_use[a] ? quo[2*a] : '0;
      et = side.et_use[a] ? quo[2*a+1] : ONE_T;
      if (side.miss[a]) begin
        alive = 1'b0;
      end
      if (st > fst) begin
        fst = st;
        code = sbst_pkg::face_code(2'(a), side.fwd[a]);
      end
      if (et < fet) begin
        fet = et;
      end
      if (fet < fst) begin
        alive = 1'b0;
      end
    end
    hit = alive;
    hit_time = alive ? fst : '0;
    normal_code = alive ? code : sbst_pkg::FACE_NONE;
  end

endmodule
`default_nettype wire

FILE: dv/segment_box_slab_test_top_test.sv
// Self-checking testbench for the segment versus axis-aligned box slab test.
// Drives segments and box writes through the channel interfaces in sv/sbst_ifs.sv and
// checks each result against a listed expected value or the slab predictor on sbst_pkg.
`default_nettype none
module segment_box_slab_test_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int TW = FB + 1;
  localparam int LATENCY = FB + 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_RANDOM = 1850;

  typedef struct {
    logic signed [31:0] s[3];
    logic signed [31:0] e[3];
  } segment_t;

  typedef struct {
    logic hit;
    logic [TW-1:0] hit_time;
    logic [sbst_pkg::CODE_W-1:0] normal_code;
  } box_hit_t;

  typedef struct {
    segment_t seg;
    logic known;
    box_hit_t want;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int mismatches = 0;
  int idle_cycles = 0;
  int out_wait = 0;
  logic stim_done = 1'b0;
  logic signed [31:0] box_lo[3];
  logic signed [31:0] box_hi[3];
  box_hit_t hits_pending[$];
  box_hit_t known_pending[$];
  logic known_flags[$];
  seg_row_t rows[$];

  sbst_seg_if in_ch();
  sbst_res_if #(.TIME_W(TW)) out_ch();
  sbst_cfg_if cfg_ch();

  segment_box_slab_test_top #(.FRACTION_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] slab_ratio(longint num, longint den);
    longint unsigned n, d, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (d == 0) return 64'(1) << FB;
    q = (n << FB) / d;
    return q > (64'(1) << FB) ? (64'(1) << FB) : q;
  endfunction

  function automatic box_hit_t predict_hit(segment_t g);
    box_hit_t r;
    longint lo, hi, s, e;
    logic [63:0] t_in, t_out, st, et;
    logic [sbst_pkg::CODE_W-1:0] code, face;
    r.hit = 1'b0;
    r.hit_time = '0;
    r.normal_code = sbst_pkg::FACE_NONE;
    t_in = 0;
    t_out = 64'(1) << FB;
    code = sbst_pkg::FACE_NONE;
    for (int a = 0; a < 3; a++) begin
      lo = box_lo[a];
      hi = box_hi[a];
      s = g.s[a];
      e = g.e[a];
      if (s < e) begin
        if (s > hi || e < lo) return r;
        st = (s < lo) ? slab_ratio(lo - s, e - s) : 0;
        et = (e > hi) ? slab_ratio(hi - s, e - s) : (64'(1) << FB);
        face = sbst_pkg::CODE_W'(2 * a + 1);
      end else begin
        if (e > hi || s < lo) return r;
        st = (s > hi) ? slab_ratio(hi - s, e - s) : 0;
        et = (e < lo) ? slab_ratio(lo - s, e - s) : (64'(1) << FB);
        face = sbst_pkg::CODE_W'(2 * a + 2);
      end
      if (st > t_in) begin
        t_in = st;
        code = face;
      end
      if (et < t_out) t_out = et;
      if (t_out < t_in) return r;
    end
    r.hit = 1'b1;
    r.hit_time = t_in[TW-1:0];
    r.normal_code = code;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic write_box(sbst_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx <= sbst_pkg::REG_BOX_MIN_Z) box_lo[idx] = val;
    else box_hi[idx - sbst_pkg::REG_BOX_MAX_X] = val;
  endtask

  task automatic write_stray(logic [sbst_pkg::IDX_W-1:0] idx, logic [31:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_box(logic [31:0] l[3], logic [31:0] h[3]);
    write_box(sbst_pkg::REG_BOX_MIN_X, l[0]);
    write_box(sbst_pkg::REG_BOX_MIN_Y, l[1]);
    write_box(sbst_pkg::REG_BOX_MIN_Z, l[2]);
    write_box(sbst_pkg::REG_BOX_MAX_X, h[0]);
    write_box(sbst_pkg::REG_BOX_MAX_Y, h[1]);
    write_box(sbst_pkg::REG_BOX_MAX_Z, h[2]);
  endtask

  task automatic send_segment(segment_t g, logic known, box_hit_t want);
    repeat ($urandom_range(0, 8) * ($urandom_range(0, 3) != 0)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.start_x <= g.s[0];
    in_ch.start_y <= g.s[1];
    in_ch.start_z <= g.s[2];
    in_ch.end_x <= g.e[0];
    in_ch.end_y <= g.e[1];
    in_ch.end_z <= g.e[2];
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    hits_pending.push_back(predict_hit(g));
    known_flags.push_back(known);
    known_pending.push_back(want);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (hits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] lo, logic [31:0] hi);
    int unsigned k;
    logic signed [31:0] span;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom();
    if (k == 1) return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
    span = $signed(hi) - $signed(lo);
    if (span <= 0) span = 32'h0004_0000;
    return $signed(lo) + $signed(32'($urandom_range(0, 32'h7fff)) * (span >>> 12))
           - (span >>> 2);
  endfunction

  function automatic segment_t rand_segment();
    segment_t g;
    for (int a = 0; a < 3; a++) begin
      g.s[a] = rand_coord(box_lo[a], box_hi[a]);
      g.e[a] = ($urandom_range(0, 15) == 0) ? g.s[a] : rand_coord(box_lo[a], box_hi[a]);
    end
    return g;
  endfunction

  function automatic segment_t mk_seg(int sx, int sy, int sz, int ex, int ey, int ez);
    segment_t g;
    g.s[0] = sx; g.s[1] = sy; g.s[2] = sz;
    g.e[0] = ex; g.e[1] = ey; g.e[2] = ez;
    return g;
  endfunction

  function automatic box_hit_t mk_hit(logic h, int t, int c);
    box_hit_t r;
    r.hit = h;
    r.hit_time = TW'(t);
    r.normal_code = sbst_pkg::CODE_W'(c);
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (hits_pending.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        box_hit_t w, k;
        logic kf;
        w = hits_pending.pop_front();
        k = known_pending.pop_front();
        kf = known_flags.pop_front();
        if (kf) w = k;
        if (out_ch.hit !== w.hit) report_mismatch("hit", out_ch.hit, w.hit);
        if (out_ch.hit_time !== w.hit_time)
          report_mismatch("hit_time", out_ch.hit_time, w.hit_time);
        if (out_ch.normal_code !== w.normal_code)
          report_mismatch("normal_code", out_ch.normal_code, w.normal_code);
      end
    end
  end

  always @(posedge clk) begin
    int unsigned draw;
    draw = 0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else if (stim_done) begin
      out_ch.ready <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      draw = $urandom_range(0, 8);
      out_wait <= int'(draw);
      out_ch.ready <= (draw == 0);
    end else if (out_wait > 1) begin
      out_wait <= out_wait - 1;
    end else begin
      out_wait <= 0;
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_ch.valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] l[3], h[3];
    box_hit_t none;
    segment_t g;
    none = mk_hit(0, 0, 0);
    in_ch.valid = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_z = '0;
    in_ch.end_x = '0; in_ch.end_y = '0; in_ch.end_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = sbst_pkg::REG_BOX_MIN_X;
    cfg_ch.data = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Box at reset is the single point at the origin.
    rows.push_back('{mk_seg(0, 0, 0, 0, 0, 0), 1, mk_hit(1, 0, 0)});
    rows.push_back('{mk_seg(-65536, 0, 0, 65536, 0, 0), 1, mk_hit(1, 32768, 1)});
    rows.push_back('{mk_seg(65536, 0, 0, 65536, 0, 0), 1, none});
    foreach (rows[i]) send_segment(rows[i].seg, rows[i].known, rows[i].want);
    drain();
    rows.delete();

    // Box from 0 to 4 on every axis.
    for (int a = 0; a < 3; a++) begin
      l[a] = 0;
      h[a] = 32'h0004_0000;
    end
    set_box(l, h);
    write_stray(3'd6, 32'hdead_beef);
    write_stray(3'd7, 32'h1234_5678);
    rows.push_back('{mk_seg(65536, 65536, 65536, 131072, 131072, 131072), 1,
                     mk_hit(1, 0, 0)});
    rows.push_back('{mk_seg(-65536, 65536, 65536, 327680, 65536, 65536), 1,
                     mk_hit(1, 10922, 1)});
    rows.push_back('{mk_seg(327680, 65536, 65536, -65536, 65536, 65536), 1,
                     mk_hit(1, 10922, 2)});
    rows.push_back('{mk_seg(65536, -65536, 65536, 65536, 327680, 65536), 1,
                     mk_hit(1, 10922, 3)});
    rows.push_back('{mk_seg(65536, 327680, 65536, 65536, -65536, 65536), 1,
                     mk_hit(1, 10922, 4)});
    rows.push_back('{mk_seg(65536, 65536, -65536, 65536, 65536, 327680), 1,
                     mk_hit(1, 10922, 5)});
    rows.push_back('{mk_seg(65536, 65536, 327680, 65536, 65536, -65536), 1,
                     mk_hit(1, 10922, 6)});
    rows.push_back('{mk_seg(-65536, -65536, 65536, 327680, 327680, 65536), 1,
                     mk_hit(1, 10922, 1)});
    rows.push_back('{mk_seg(-131072, 65536, 65536, -65536, 65536, 65536), 1, none});
    rows.push_back('{mk_seg(-65536, 65536, 65536, 0, 65536, 65536), 1,
                     mk_hit(1, 65536, 1)});
    rows.push_back('{mk_seg(65536, 65536, 65536, 65536, 65536, 65536), 1,
                     mk_hit(1, 0, 0)});
    rows.push_back('{mk_seg(-65536, 65536, 65536, -65536, 131072, 131072), 1, none});
    rows.push_back('{mk_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 0, none});
    rows.push_back('{mk_seg(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, none});
    rows.push_back('{mk_seg(-65536, -131072, 65536, 327680, 262144, 65536), 0, none});
    rows.push_back('{mk_seg(-65536, 65536, 65536, 65536, 655360, 65536), 0, none});
    foreach (rows[i]) send_segment(rows[i].seg, rows[i].known, rows[i].want);
    drain();

    // Extreme and inverted boxes, then random boxes.
    for (int phase = 0; phase < 8; phase++) begin
      for (int a = 0; a < 3; a++) begin
        case (phase)
          0: begin
            l[a] = 32'h8000_0000;
            h[a] = 32'h7fff_ffff;
          end
          1: begin
            l[a] = 32'h0005_0000;
            h[a] = 32'hfffb_0000;
          end
          default: begin
            l[a] = $urandom();
            l[a] = $signed(l[a]) >>> $urandom_range(0, 16);
            h[a] = $signed(l[a]) + $signed(32'($urandom_range(0, 32'h00ff_ffff)) >>>
                   $urandom_range(0, 8));
          end
        endcase
      end
      set_box(l, h);
      for (int n = 0; n < NUM_RANDOM / 8; n++) begin
        g = rand_segment();
        send_segment(g, 1'b0, none);
      end
      drain();
    end

    stim_done <= 1'b1;
    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: segment_box_slab_test_top.f
sv/sbst_pkg.sv
sv/sbst_ifs.sv
sv/sbst_front.sv
sv/sbst_div_cell.sv
sv/sbst_resolve.sv
sv/segment_box_slab_test_top.sv
dv/segment_box_slab_test_top_test.sv
